// ===== hdl/mmc_pkg.sv =====
package mmc_pkg;

    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;               // index into the axis arrays
    localparam int RAW_W    = 16;              // raw sample
    localparam int RNG_W    = 16;              // axis range, max - min
    localparam int SUM_W    = 18;              // sum of three ranges
    localparam int MAG_W    = 17;              // |2*raw - min - max|
    localparam int DVS_W    = 18;              // divisor, 3 * range
    localparam int DIVD_W   = 34;              // dividend, sum << 16
    localparam int QUO_W    = 32;              // scale, Q16.16
    localparam int CNT_W    = 6;
    localparam int DIV_STEPS = DIVD_W;         // one quotient bit per step
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int CAL_W    = 32;              // Q24.8
    localparam int AVG_W    = 24;              // Q16.8

    // floor(x / 3) == (x * RECIP3) >> 33 for any x below 2**32
    localparam logic [MUL_B_W-1:0] RECIP3 = 32'hAAAA_AAAB;
    localparam int RECIP3_SHIFT = 33;
    localparam int CAL_SHIFT    = 9;           // Q16.16 * Q.1 down to Q24.8

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RANGE = 9'b000000010,
        S_AVG   = 9'b000000100,
        S_AVGW  = 9'b000001000,
        S_DLOAD = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_CAL   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

endpackage

// ===== hdl/mag_minmax_calibration.sv =====
// Min/max hard- and soft-iron calibration of a three-axis magnetometer.
// Input channel: i_valid / o_stall carry one raw sample (i_mag_x/y/z). A
// transaction completes on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result per sample: calibrated
// axes (Q24.8), average range (Q16.8), per-axis scale (Q16.16), zero_range.
// Work per sample is sequenced over one shared restoring divider (one
// quotient bit per cycle) and one shared multiplier.
// An axis with zero range skips the divider and the multiplier. o_stall
// is high from the accepted transaction until the sequencer returns to
// idle, so a new sample is not taken while the last one is worked on.
// The result sits in an output register; a new sample is taken while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds in its final state and o_stall stays high.
// Reset (synchronous, active low) clears running min/max to zero, drops
// o_valid and returns the sequencer to idle.
module mag_minmax_calibration
    import mmc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [RAW_W-1:0]  i_mag_x,
    input  logic signed [RAW_W-1:0]  i_mag_y,
    input  logic signed [RAW_W-1:0]  i_mag_z,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [CAL_W-1:0]  o_cal_x,
    output logic signed [CAL_W-1:0]  o_cal_y,
    output logic signed [CAL_W-1:0]  o_cal_z,
    output logic [AVG_W-1:0]         o_avg_range,
    output logic [QUO_W-1:0]         o_scale_x,
    output logic [QUO_W-1:0]         o_scale_y,
    output logic [QUO_W-1:0]         o_scale_z,
    output logic                     o_zero_range
);

    t_state r_state, n_state;

    // running extremes, start at zero
    logic signed [RAW_W-1:0] r_min [AXES];
    logic signed [RAW_W-1:0] r_max [AXES];
    logic signed [RAW_W-1:0] r_raw [AXES];
    logic signed [RAW_W-1:0] w_in  [AXES];

    // per-axis working values
    logic [RNG_W-1:0]  r_range [AXES];
    logic [MAG_W-1:0]  r_mag   [AXES];
    logic              r_neg   [AXES];
    logic [SUM_W-1:0]  r_sum;
    logic              r_zero;
    logic [AXIS_W-1:0] r_axis;

    // shared divider
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVS_W:0]    w_trial;
    logic              w_ge;
    logic [DVS_W:0]    w_diff;

    // shared multiplier
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]  r_prod;

    // finished results
    logic [AVG_W-1:0]        r_avg;
    logic [QUO_W-1:0]        r_scale [AXES];
    logic signed [CAL_W-1:0] r_cal   [AXES];

    logic                    r_ovalid;
    logic signed [CAL_W-1:0] r_ocal   [AXES];
    logic [QUO_W-1:0]        r_oscale [AXES];
    logic [AVG_W-1:0]        r_oavg;
    logic                    r_ozero;

    logic w_in_acc;
    logic w_out_free;

    // combinational per-axis terms from the updated extremes
    logic [RNG_W-1:0]        w_range    [AXES];
    logic signed [SUM_W-1:0] w_d        [AXES];
    logic signed [SUM_W-1:0] w_dabs     [AXES];
    logic [SUM_W-1:0]        w_sum;
    logic                    w_zero;
    logic [CAL_W-1:0]        w_cal_mag;
    logic signed [CAL_W-1:0] w_cal;
    logic                    w_last_axis;

    assign w_in[0] = i_mag_x;
    assign w_in[1] = i_mag_y;
    assign w_in[2] = i_mag_z;

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_last_axis = (r_axis == AXIS_W'(AXES - 1));

    always_comb begin
        w_sum  = '0;
        w_zero = 1'b0;
        for (int i = 0; i < AXES; i++) begin
            // max >= 0 >= min, so the 16-bit difference is exact
            w_range[i]    = RNG_W'(r_max[i] - r_min[i]);
            w_sum         = w_sum + SUM_W'(w_range[i]);
            if (w_range[i] == '0) begin
                w_zero = 1'b1;
            end
            // d = 2*raw - min - max; |d| <= range
            w_d[i]    = SUM_W'(signed'({r_raw[i], 1'b0})) - SUM_W'(r_min[i]) - SUM_W'(r_max[i]);
            w_dabs[i] = w_d[i][SUM_W-1] ? -w_d[i] : w_d[i];
        end
    end

    // restoring divider step
    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // one multiplier: sum*256 by 1/3, then |d| by scale
    always_comb begin
        if (r_state == S_AVG) begin
            w_mul_a = {r_sum, 8'b0};
            w_mul_b = RECIP3;
        end else begin
            w_mul_a = {{(MUL_A_W-MAG_W){1'b0}}, r_mag[r_axis]};
            w_mul_b = r_quo[QUO_W-1:0];
        end
    end
    assign w_prod = {{MUL_B_W{1'b0}}, w_mul_a} * {{MUL_A_W{1'b0}}, w_mul_b};

    // truncation toward zero: shift the magnitude, then restore the sign
    assign w_cal_mag = r_prod[CAL_SHIFT +: CAL_W];
    assign w_cal     = r_neg[r_axis] ? -signed'(w_cal_mag) : signed'(w_cal_mag);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_RANGE;
            S_RANGE: n_state = S_AVG;
            S_AVG:   n_state = S_AVGW;
            S_AVGW:  n_state = S_DLOAD;
            S_DLOAD: begin
                if (r_range[r_axis] != '0) begin
                    n_state = S_DIV;
                end else if (w_last_axis) begin
                    n_state = S_OUT;
                end
            end
            S_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_MUL;
            S_MUL:   n_state = S_CAL;
            S_CAL:   n_state = w_last_axis ? S_OUT : S_DLOAD;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_min[i] <= '0;
                r_max[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                for (int i = 0; i < AXES; i++) begin
                    if (w_in[i] < r_min[i]) r_min[i] <= w_in[i];
                    if (w_in[i] > r_max[i]) r_max[i] <= w_in[i];
                end
            end
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < AXES; i++) begin
                r_raw[i] <= w_in[i];
            end
        end

        case (r_state)
            S_RANGE: begin
                for (int i = 0; i < AXES; i++) begin
                    r_range[i] <= w_range[i];
                    r_mag[i]   <= w_dabs[i][MAG_W-1:0];
                    r_neg[i]   <= w_d[i][SUM_W-1];
                end
                r_sum  <= w_sum;
                r_zero <= w_zero;
                r_axis <= '0;
            end
            S_AVG: begin
                r_prod <= w_prod;
            end
            S_AVGW: begin
                r_avg <= r_prod[RECIP3_SHIFT +: AVG_W];
            end
            S_DLOAD: begin
                r_quo <= {r_sum, 16'b0};
                r_rem <= '0;
                r_cnt <= '0;
                r_dvs <= {2'b0, r_range[r_axis]} + {1'b0, r_range[r_axis], 1'b0};
                if (r_range[r_axis] == '0) begin
                    r_scale[r_axis] <= '0;
                    r_cal[r_axis]   <= '0;
                    r_axis          <= r_axis + AXIS_W'(1);
                end
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], w_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_MUL: begin
                r_prod <= w_prod;
            end
            S_CAL: begin
                r_scale[r_axis] <= r_quo[QUO_W-1:0];
                r_cal[r_axis]   <= w_cal;
                r_axis          <= r_axis + AXIS_W'(1);
            end
            S_OUT: begin
                if (w_out_free) begin
                    for (int i = 0; i < AXES; i++) begin
                        r_ocal[i]   <= r_cal[i];
                        r_oscale[i] <= r_scale[i];
                    end
                    r_oavg  <= r_avg;
                    r_ozero <= r_zero;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_cal_x      = r_ocal[0];
    assign o_cal_y      = r_ocal[1];
    assign o_cal_z      = r_ocal[2];
    assign o_scale_x    = r_oscale[0];
    assign o_scale_y    = r_oscale[1];
    assign o_scale_z    = r_oscale[2];
    assign o_avg_range  = r_oavg;
    assign o_zero_range = r_ozero;

    // no zero range flagged means every axis got a real scale
    a_scale_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_zero_range |->
            (o_scale_x != '0) && (o_scale_y != '0) && (o_scale_z != '0))
        else $error("scale zero without zero_range");

    // a zero scale forces a zero calibrated value
    a_cal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_scale_x != '0) || (o_cal_x == '0)) &&
                    ((o_scale_y != '0) || (o_cal_y == '0)) &&
                    ((o_scale_z != '0) || (o_cal_z == '0)))
        else $error("nonzero cal on zero-range axis");

    // extremes always bracket zero
    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min[0] <= 0) && (r_max[0] >= 0) && (r_min[1] <= 0) && (r_max[1] >= 0) &&
        (r_min[2] <= 0) && (r_max[2] >= 0))
        else $error("running min/max lost zero");

    // divider count stays within the step count
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider overran");

    // an accepted transaction starts the sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_RANGE))
        else $error("sequencer did not start");

endmodule
